// ----- hw/rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/fatcw_pkg.sv -----
package fatcw_pkg;

   localparam int TableDepth = 8192;
   localparam int AddrWidth  = $clog2(TableDepth);
   localparam int CountWidth = 14;
   localparam logic [15:0] EndMark = 16'hFFFF;

   localparam logic [2:0] ReqLocate = 3'd0;
   localparam logic [2:0] ReqAlloc  = 3'd1;
   localparam logic [2:0] ReqCount  = 3'd2;
   localparam logic [2:0] ReqWrite  = 3'd3;
   localparam logic [2:0] ReqRead   = 3'd4;

   localparam logic [1:0] StOk     = 2'd0;
   localparam logic [1:0] StNoFree = 2'd1;
   localparam logic [1:0] StRange  = 2'd2;

   typedef struct packed {
      logic                 we;
      logic [AddrWidth-1:0] waddr;
      logic [15:0]          wdata;
      logic [AddrWidth-1:0] raddr;
   } mem_ctl_type;

endpackage

// ----- hw/rtl/fat_chain_walk_and_allocate.sv -----
// channel | direction | beat contents
// req     | in        | tdata: req_type[2:0], block_index[18:3], block_position[34:19],
//         |           |        entry_value[50:35], zero pad to 56
// rsp     | out       | tdata: result_block[15:0], free_count[29:16], status[31:30]
// csr     | in        | data_block_count[13:0]
// each request runs to its result beat before the next is taken. write needs one table
// write, read one table read, locate one read per hop (none for zero hops), count a full
// scan of all n entries, allocate a scan down from n-1 until a free entry is found, one
// entry read per cycle through the table ram (one write port, registered read port). reset
// clears control only; the table content is undefined until written. a held result does
// not block csr writes; a new request is taken once the previous result beat has gone.
module fat_chain_walk_and_allocate (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // req_type, block_index, block_position, entry_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_block, free_count, status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [13:0] csr_data
);
   import fatcw_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [2:0] {S_IDLE, S_RD, S_WALK, S_SCAN, S_LINK, S_OUT} state_type;

   state_type        state_ff, state_in;
   logic [13:0]      dbc_ff;
   logic [2:0]       type_ff, type_in;
   logic [15:0]      idx_ff, idx_in, hops_ff, hops_in, val_ff, val_in;
   logic [15:0]      cur_ff, cur_in, res_ff, res_in;
   logic [13:0]      cnt_ff, cnt_in;
   logic [1:0]       st_ff, st_in;
   logic [14:0]      scan_ff, scan_in;   // next address issued (count); last address issued (allocate)
   logic             found_ff, found_in;
   logic [15:0]      pick_ff, pick_in;
   logic [AddrWidth-1:0] last_ff, last_in;  // address whose data returns now
   logic             pend_ff, pend_in;
   mem_ctl_type      ctl;
   logic [15:0]      rdata;
   logic [14:0]      n;

   fatcw_table_ram u_ram (.clock(clock), .ctl(ctl), .rdata(rdata));

   assign n = (int'(dbc_ff) > TableDepth) ? 15'(TableDepth) : {1'b0, dbc_ff};
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {st_ff, cnt_ff, res_ff};

   always_comb begin
      state_in = state_ff; type_in = type_ff; idx_in = idx_ff; hops_in = hops_ff;
      val_in = val_ff; cur_in = cur_ff; res_in = res_ff; cnt_in = cnt_ff; st_in = st_ff;
      scan_in = scan_ff; found_in = found_ff; pick_in = pick_ff; last_in = last_ff;
      pend_in = 1'b0;
      ctl = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               type_in = req_tdata[2:0];
               idx_in  = req_tdata[18:3];
               hops_in = req_tdata[34:19];
               val_in  = req_tdata[50:35];
               state_in = S_RD;
            end
         end
         S_RD: begin
            res_in = 16'd0; cnt_in = '0; st_in = StOk; found_in = 1'b0;
            cur_in = idx_ff; state_in = S_OUT;
            case (type_ff)
               ReqLocate: begin
                  if (idx_ff >= {1'b0, n}) begin
                     res_in = idx_ff; st_in = StRange;
                  end else if (hops_ff == 16'd0) begin
                     res_in = idx_ff;
                  end else begin
                     ctl.raddr = idx_ff[AddrWidth-1:0];
                     pend_in = 1'b1; state_in = S_WALK;
                  end
               end
               ReqAlloc: begin
                  if (idx_ff != EndMark && idx_ff >= {1'b0, n}) begin
                     st_in = StRange;
                  end else begin
                     scan_in = n; state_in = S_SCAN;  // scan down from n-1
                  end
               end
               ReqCount: begin
                  scan_in = '0; state_in = S_SCAN;
               end
               ReqWrite: begin
                  if (idx_ff >= {1'b0, n}) st_in = StRange;
                  else begin
                     ctl.we = 1'b1; ctl.waddr = idx_ff[AddrWidth-1:0]; ctl.wdata = val_ff;
                  end
               end
               ReqRead: begin
                  if (idx_ff >= {1'b0, n}) st_in = StRange;
                  else begin
                     ctl.raddr = idx_ff[AddrWidth-1:0]; pend_in = 1'b1; state_in = S_WALK;
                  end
               end
               default: ;
            endcase
         end
         S_WALK: begin
            // each hop issues the read of cur while pend is clear and consumes the returned data while pend is set
            if (!pend_ff) begin
               ctl.raddr = cur_ff[AddrWidth-1:0]; pend_in = 1'b1;
            end else if (type_ff == ReqRead) begin
               res_in = rdata; state_in = S_OUT;
            end else if (rdata == 16'd0 || rdata == EndMark) begin
               res_in = cur_ff; state_in = S_OUT;
            end else if (rdata >= {1'b0, n}) begin
               res_in = rdata; st_in = StRange; state_in = S_OUT;
            end else begin
               cur_in = rdata; hops_in = hops_ff - 16'd1;
               if (hops_ff == 16'd1) begin
                  res_in = rdata; state_in = S_OUT;
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && rdata == 16'd0) begin
               if (type_ff == ReqCount) cnt_in = cnt_ff + 14'd1;
               else if (!found_ff) begin
                  found_in = 1'b1; pick_in = 16'(last_ff);
               end
            end
            if (type_ff == ReqCount) begin
               if (scan_ff < n) begin
                  ctl.raddr = scan_ff[AddrWidth-1:0]; last_in = scan_ff[AddrWidth-1:0];
                  pend_in = 1'b1; scan_in = scan_ff + 15'd1;
               end else if (!pend_ff) state_in = S_OUT;
            end else begin
               if (scan_ff != '0 && !found_in) begin
                  ctl.raddr = AddrWidth'(scan_ff - 15'd1);
                  last_in = AddrWidth'(scan_ff - 15'd1);
                  pend_in = 1'b1; scan_in = scan_ff - 15'd1;
               end else if (!pend_ff || found_in) begin
                  state_in = S_LINK;
               end
            end
         end
         S_LINK: begin
            if (!found_ff) begin
               res_in = EndMark; st_in = StNoFree; state_in = S_OUT;
            end else if (idx_ff != EndMark && idx_ff != pick_ff) begin
               ctl.we = 1'b1; ctl.waddr = idx_ff[AddrWidth-1:0]; ctl.wdata = pick_ff;
               idx_in = EndMark;
            end else begin
               ctl.we = 1'b1; ctl.waddr = pick_ff[AddrWidth-1:0]; ctl.wdata = EndMark;
               res_in = pick_ff; state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dbc_ff   <= 14'd8192;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
         if (csr_valid) dbc_ff <= csr_data;
      end
      type_ff <= type_in; idx_ff <= idx_in; hops_ff <= hops_in; val_ff <= val_in;
      cur_ff <= cur_in; res_ff <= res_in; cnt_ff <= cnt_in; st_ff <= st_in;
      scan_ff <= scan_in; pick_ff <= pick_in; last_ff <= last_in;
   end

   `ASSERT_ALWAYS(a_no_write_in_scan, clock, reset, !(state_ff == S_SCAN && ctl.we),
      "table written during scan")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
      "result beat dropped")
   `ASSERT_ALWAYS(a_status_code, clock, reset, !rsp_tvalid || st_ff <= StRange,
      "bad status code")
endmodule

// ----- hw/rtl/fatcw_table_ram.sv -----
module fatcw_table_ram (
   input  logic                        clock,
   input  fatcw_pkg::mem_ctl_type      ctl,
   output logic [15:0]                 rdata
);
   import fatcw_pkg::*;

   logic [15:0] mem [TableDepth];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rdata <= mem[ctl.raddr];
   end
endmodule
